// ===== rtl/rdm_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// RDM frame parser assertion macros
// Clocked, reset-qualified assertion shorthands for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef RDM_FRAME_PARSER_MACROS_SVH
`define RDM_FRAME_PARSER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define RDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RDM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rdm_fp_pkg.sv =====
// ----------------------------------------------------------------------------
// RDM frame parser package
// Transfer types, status and register codes, frame byte positions.
// ----------------------------------------------------------------------------
`default_nettype none

package rdm_fp_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned POS_W     = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CODE     = 1'b0,
    CFG_SUB_START_CODE = 1'b1
  } rdm_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_SUB   = 3'd3,
    ST_LEN_MIN   = 3'd4,
    ST_PDL       = 3'd5,
    ST_CHECKSUM  = 3'd6
  } rdm_status_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } rdm_kind_e;

  localparam logic [7:0] RST_START_CODE     = 8'd204;
  localparam logic [7:0] RST_SUB_START_CODE = 8'd1;
  localparam logic [7:0] MIN_MSG_LEN        = 8'd24;

  // byte positions within a frame
  localparam logic [POS_W-1:0] POS_START       = 9'd0;
  localparam logic [POS_W-1:0] POS_SUB         = 9'd1;
  localparam logic [POS_W-1:0] POS_LEN         = 9'd2;
  localparam logic [POS_W-1:0] POS_DEST_LAST   = 9'd8;
  localparam logic [POS_W-1:0] POS_SRC_LAST    = 9'd14;
  localparam logic [POS_W-1:0] POS_HDR_FIRST   = 9'd15;
  localparam logic [POS_W-1:0] POS_HDR_LAST    = 9'd17;
  localparam logic [POS_W-1:0] POS_SUBDEV_LAST = 9'd19;
  localparam logic [POS_W-1:0] POS_CMD_CLASS   = 9'd20;
  localparam logic [POS_W-1:0] POS_PID_LAST    = 9'd22;
  localparam logic [POS_W-1:0] POS_PDL         = 9'd23;
  localparam logic [POS_W-1:0] POS_PAYLOAD     = 9'd24;
  localparam logic [POS_W-1:0] POS_HDR_REPORT  = 9'd25;
  localparam logic [POS_W-1:0] POS_MAX         = 9'd511;

  localparam logic [1:0] HDR_CMD_CLASS = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } rdm_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [47:0] destination_uid;
    logic [47:0] source_uid;
    logic [7:0]  transaction_number;
    logic [7:0]  port_or_response;
    logic [7:0]  message_count;
    logic [15:0] sub_dev_num;
    logic [7:0]  command_class;
    logic [15:0] parameter_id;
    logic [7:0]  param_data_length;
  } rdm_out_t;

  typedef struct packed {
    logic     valid;
    rdm_out_t item;
  } rdm_fp_push_t;

endpackage

`default_nettype wire

// ===== rtl/rdm_frame_parser.sv =====
// ----------------------------------------------------------------------------
// RDM frame parser
// Byte-stream RDM frame checker and field unpacker, top level.
// ----------------------------------------------------------------------------
// Input channel: one received byte per transfer, end_of_buffer set on the
//   buffer's last byte. Output channel: parameter data bytes as they arrive,
//   then one summary per buffer with status and the unpacked header fields
//   (fields are zero unless status is ok). Bytes after the summary, up to
//   end_of_buffer, give no transfer.
// Throughput: one byte per cycle while in_stall_o is low; each byte is fully
//   handled by the byte engine in the cycle it is taken.
// Result path: the result for a taken byte is registered in the output
//   register, or in the skid entry while the output register is held.
// Stall: the output has a result register plus one skid entry; input stalls
//   only when both are occupied, so bytes keep flowing while one result waits.
// Reset: clears frame state and loads start code 0xCC and sub start code 0x01.
// Configuration writes are accepted at any edge with cfg_we_i; change them only
//   while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rdm_frame_parser_macros.svh"

module rdm_frame_parser import rdm_fp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire rdm_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rdm_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_wdata_i
);

  logic [7:0]   start_byte_q;
  logic [7:0]   sub_byte_q;
  logic         take;
  logic         full;
  logic         out_is_data;
  rdm_fp_push_t push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= RST_START_CODE;
      sub_byte_q   <= RST_SUB_START_CODE;
    end else if (cfg_we_i) begin
      unique case (rdm_cfg_idx_e'(cfg_index_i))
        CFG_START_CODE:     start_byte_q <= cfg_wdata_i;
        CFG_SUB_START_CODE: sub_byte_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o  = full;
  assign take        = in_valid_i && !full;
  assign out_is_data = out_valid_o && (out_data_o.item_kind == KIND_DATA);

  rdm_fp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .in_data_i    (in_data_i),
    .start_byte_i (start_byte_q),
    .sub_byte_i   (sub_byte_q),
    .push_o       (push)
  );

  rdm_fp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .full_o      (full)
  );

  `RDM_ASSERT_IMPL(a_skid_needs_out, in_stall_o, out_valid_o, "skid full with empty output")
  `RDM_ASSERT_IMPL(a_push_on_take, push.valid, take, "result without a taken byte")
  `RDM_ASSERT_IMPL(a_data_status, out_is_data, out_data_o.status == ST_OK, "data status not ok")

endmodule

`default_nettype wire

// ===== rtl/rdm_fp_parser.sv =====
// ----------------------------------------------------------------------------
// RDM frame parser byte engine
// Per-byte frame state, header capture, checksum and result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_fp_parser import rdm_fp_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         take_i,
  input  wire rdm_in_t      in_data_i,
  input  wire logic [7:0]   start_byte_i,
  input  wire logic [7:0]   sub_byte_i,
  output rdm_fp_push_t      push_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       decl_len_q, decl_len_d;
  logic [7:0]       data_len_q, data_len_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       cs_high_q, cs_high_d;
  logic [47:0]      dest_uid_q, dest_uid_d;
  logic [47:0]      src_uid_q, src_uid_d;
  logic [7:0]       hdr_q [4];
  logic [7:0]       hdr_d [4];
  logic [15:0]      sub_dev_q, sub_dev_d;
  logic [15:0]      pid_q, pid_d;
  logic             skip_q, skip_d;
  rdm_status_e      hs_q, hs_d;

  logic [7:0]       b;
  logic             eob;
  logic [1:0]       hdr_rel;
  logic [POS_W-1:0] decl_ext;
  logic             summary;
  rdm_status_e      sum_status;

  assign b        = in_data_i.rx_byte;
  assign eob      = in_data_i.end_of_buffer;
  assign hdr_rel  = pos_q[1:0] - POS_HDR_FIRST[1:0];
  assign decl_ext = {1'b0, decl_len_q};

  always_comb begin
    pos_d      = pos_q;
    decl_len_d = decl_len_q;
    data_len_d = data_len_q;
    sum_d      = sum_q;
    cs_high_d  = cs_high_q;
    dest_uid_d = dest_uid_q;
    src_uid_d  = src_uid_q;
    hdr_d      = hdr_q;
    sub_dev_d  = sub_dev_q;
    pid_d      = pid_q;
    skip_d     = skip_q;
    hs_d       = hs_q;
    push_o     = '0;
    summary    = 1'b0;
    sum_status = ST_SHORT;

    if (take_i && !skip_q) begin
      if (pos_q <= POS_LEN || pos_q < decl_ext) begin
        sum_d = sum_q + {8'd0, b};
      end

      if (pos_q == POS_START) begin
        if (b != start_byte_i && hs_q == ST_OK) hs_d = ST_BAD_START;
      end else if (pos_q == POS_SUB) begin
        if (b != sub_byte_i && hs_q == ST_OK) hs_d = ST_BAD_SUB;
      end else if (pos_q == POS_LEN) begin
        decl_len_d = b;
        if (b < MIN_MSG_LEN && hs_q == ST_OK) hs_d = ST_LEN_MIN;
      end else if (pos_q <= POS_DEST_LAST) begin
        dest_uid_d = {dest_uid_q[39:0], b};
      end else if (pos_q <= POS_SRC_LAST) begin
        src_uid_d = {src_uid_q[39:0], b};
      end else if (pos_q <= POS_HDR_LAST) begin
        hdr_d[hdr_rel] = b;
      end else if (pos_q <= POS_SUBDEV_LAST) begin
        sub_dev_d = {sub_dev_q[7:0], b};
      end else if (pos_q == POS_CMD_CLASS) begin
        hdr_d[HDR_CMD_CLASS] = b;
      end else if (pos_q <= POS_PID_LAST) begin
        pid_d = {pid_q[7:0], b};
      end else if (pos_q == POS_PDL) begin
        data_len_d = b;
        if (decl_len_q != (MIN_MSG_LEN + b) && hs_q == ST_OK) hs_d = ST_PDL;
      end

      if (pos_q >= POS_PAYLOAD && hs_q == ST_OK) begin
        if (pos_q < decl_ext) begin
          push_o.valid          = 1'b1;
          push_o.item.item_kind = KIND_DATA;
          push_o.item.data_byte = b;
        end else if (pos_q == decl_ext) begin
          cs_high_d = b;
        end else if (pos_q == decl_ext + 9'd1) begin
          summary    = 1'b1;
          sum_status = ({cs_high_q, b} == sum_q) ? ST_OK : ST_CHECKSUM;
        end
      end else if (hs_q != ST_OK && pos_q == POS_HDR_REPORT) begin
        summary    = 1'b1;
        sum_status = hs_q;
      end

      if (!summary && eob) begin
        summary    = 1'b1;
        sum_status = ST_SHORT;
      end

      if (summary) begin
        skip_d                = 1'b1;
        push_o                = '0;
        push_o.valid          = 1'b1;
        push_o.item.item_kind = KIND_SUMMARY;
        push_o.item.status    = sum_status;
        if (sum_status == ST_OK) begin
          push_o.item.destination_uid    = dest_uid_q;
          push_o.item.source_uid         = src_uid_q;
          push_o.item.transaction_number = hdr_q[0];
          push_o.item.port_or_response   = hdr_q[1];
          push_o.item.message_count      = hdr_q[2];
          push_o.item.sub_dev_num        = sub_dev_q;
          push_o.item.command_class      = hdr_q[HDR_CMD_CLASS];
          push_o.item.parameter_id       = pid_q;
          push_o.item.param_data_length  = data_len_q;
        end
      end

      if (pos_q != POS_MAX) pos_d = pos_q + 9'd1;
    end

    if (take_i && eob) begin
      pos_d      = '0;
      decl_len_d = '0;
      data_len_d = '0;
      sum_d      = '0;
      cs_high_d  = '0;
      dest_uid_d = '0;
      src_uid_d  = '0;
      hdr_d      = '{default: '0};
      sub_dev_d  = '0;
      pid_d      = '0;
      skip_d     = 1'b0;
      hs_d       = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      decl_len_q <= '0;
      data_len_q <= '0;
      sum_q      <= '0;
      cs_high_q  <= '0;
      dest_uid_q <= '0;
      src_uid_q  <= '0;
      hdr_q      <= '{default: '0};
      sub_dev_q  <= '0;
      pid_q      <= '0;
      skip_q     <= 1'b0;
      hs_q       <= ST_OK;
    end else begin
      pos_q      <= pos_d;
      decl_len_q <= decl_len_d;
      data_len_q <= data_len_d;
      sum_q      <= sum_d;
      cs_high_q  <= cs_high_d;
      dest_uid_q <= dest_uid_d;
      src_uid_q  <= src_uid_d;
      hdr_q      <= hdr_d;
      sub_dev_q  <= sub_dev_d;
      pid_q      <= pid_d;
      skip_q     <= skip_d;
      hs_q       <= hs_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rdm_fp_out_reg.sv =====
// ----------------------------------------------------------------------------
// RDM frame parser output stage
// Result register with one skid entry between parser and receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_fp_out_reg import rdm_fp_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rdm_fp_push_t  push_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output rdm_out_t           out_data_o,
  output logic               full_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  rdm_out_t out_q, out_d;
  rdm_out_t skid_q, skid_d;
  logic     pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = push_i.item;
        out_valid_d = push_i.valid;
      end
    end else if (push_i.valid) begin
      skid_d       = push_i.item;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full_o      = skid_valid_q;

endmodule

`default_nettype wire

// ===== test/tb_rdm_frame_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RDM frame parser testbench
// Feeds received buffers one byte per transfer, well-formed frames with random
// content plus corrupted, truncated and noise buffers, across several start
// code settings, and checks every output transfer against an in-bench model.
// ----------------------------------------------------------------------------

module tb_rdm_frame_parser;
  import rdm_fp_pkg::*;

  // Frame model: predicts the data bytes and the summary of each buffer.
  class rdm_frame_checker;
    rdm_out_t    expected_q[$];
    int          errors;
    logic [7:0]  start_byte;
    logic [7:0]  sub_code;
    logic [8:0]  pos;
    logic [7:0]  msg_len;
    logic [7:0]  pdl;
    logic [15:0] sum;
    logic [7:0]  cks_hi;
    logic [47:0] dest;
    logic [47:0] src;
    logic [7:0]  hdr[4];
    logic [15:0] subdev;
    logic [15:0] pid;
    bit          skipping;
    rdm_status_e hdr_err;

    function new();
      start_byte = RST_START_CODE;
      sub_code   = RST_SUB_START_CODE;
      errors     = 0;
      clear();
    endfunction

    function void clear();
      pos      = '0;
      msg_len  = '0;
      pdl      = '0;
      sum      = '0;
      cks_hi   = '0;
      dest     = '0;
      src      = '0;
      foreach (hdr[i]) hdr[i] = '0;
      subdev   = '0;
      pid      = '0;
      skipping = 1'b0;
      hdr_err  = ST_OK;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_summary(rdm_status_e st);
      rdm_out_t item;
      item           = '0;
      item.item_kind = KIND_SUMMARY;
      item.status    = st;
      if (st == ST_OK) begin
        item.destination_uid    = dest;
        item.source_uid         = src;
        item.transaction_number = hdr[0];
        item.port_or_response   = hdr[1];
        item.message_count      = hdr[2];
        item.sub_dev_num        = subdev;
        item.command_class      = hdr[HDR_CMD_CLASS];
        item.parameter_id       = pid;
        item.param_data_length  = pdl;
      end
      expected_q.push_back(item);
    endfunction

    function void note_byte(rdm_in_t beat);
      logic [7:0] b;
      logic       eob;
      logic [8:0] at;
      logic [7:0] want_len;
      rdm_out_t   item;
      bit         done;
      b    = beat.rx_byte;
      eob  = beat.end_of_buffer;
      at   = pos;
      done = 1'b0;
      if (skipping) begin
        if (eob) clear();
        return;
      end
      if (at <= POS_LEN || at < {1'b0, msg_len}) sum += b;
      if (at == POS_START) begin
        if (b != start_byte && hdr_err == ST_OK) hdr_err = ST_BAD_START;
      end else if (at == POS_SUB) begin
        if (b != sub_code && hdr_err == ST_OK) hdr_err = ST_BAD_SUB;
      end else if (at == POS_LEN) begin
        msg_len = b;
        if (b < MIN_MSG_LEN && hdr_err == ST_OK) hdr_err = ST_LEN_MIN;
      end else if (at <= POS_DEST_LAST) begin
        dest = {dest[39:0], b};
      end else if (at <= POS_SRC_LAST) begin
        src = {src[39:0], b};
      end else if (at <= POS_HDR_LAST) begin
        hdr[2'(at - POS_HDR_FIRST)] = b;
      end else if (at <= POS_SUBDEV_LAST) begin
        subdev = {subdev[7:0], b};
      end else if (at == POS_CMD_CLASS) begin
        hdr[HDR_CMD_CLASS] = b;
      end else if (at <= POS_PID_LAST) begin
        pid = {pid[7:0], b};
      end else if (at == POS_PDL) begin
        pdl      = b;
        want_len = MIN_MSG_LEN + b;
        if (msg_len != want_len && hdr_err == ST_OK) hdr_err = ST_PDL;
      end

      if (at >= POS_PAYLOAD && hdr_err == ST_OK) begin
        if (at < {1'b0, msg_len}) begin
          // a data byte on the buffer's last byte is replaced by the short summary
          if (!eob) begin
            item           = '0;
            item.item_kind = KIND_DATA;
            item.data_byte = b;
            expected_q.push_back(item);
          end
        end else if (at == {1'b0, msg_len}) begin
          cks_hi = b;
        end else if (at == {1'b0, msg_len} + 9'd1) begin
          push_summary(({cks_hi, b} == sum) ? ST_OK : ST_CHECKSUM);
          done = 1'b1;
        end
      end else if (hdr_err != ST_OK && at == POS_HDR_REPORT) begin
        push_summary(hdr_err);
        done = 1'b1;
      end
      if (!done && eob) begin
        push_summary(ST_SHORT);
        done = 1'b1;
      end
      if (done) skipping = 1'b1;
      if (eob) clear();
      else if (at != POS_MAX) pos = at + 9'd1;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [47:0] got, logic [47:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_item(rdm_out_t got);
      rdm_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("transfer with nothing expected: %0h", got));
        return;
      end
      want = expected_q.pop_front();
      cmp_field("item_kind", got.item_kind, want.item_kind);
      cmp_field("data_byte", got.data_byte, want.data_byte);
      cmp_field("status", got.status, want.status);
      cmp_field("destination_uid", got.destination_uid, want.destination_uid);
      cmp_field("source_uid", got.source_uid, want.source_uid);
      cmp_field("transaction_number", got.transaction_number, want.transaction_number);
      cmp_field("port_or_response", got.port_or_response, want.port_or_response);
      cmp_field("message_count", got.message_count, want.message_count);
      cmp_field("sub_dev_num", got.sub_dev_num, want.sub_dev_num);
      cmp_field("command_class", got.command_class, want.command_class);
      cmp_field("parameter_id", got.parameter_id, want.parameter_id);
      cmp_field("param_data_length", got.param_data_length, want.param_data_length);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  rdm_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rdm_out_t             out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_wdata_i = '0;

  rdm_frame_checker sb = new();

  logic [7:0] octets[$];
  logic [7:0] cur_start = RST_START_CODE;
  logic [7:0] cur_sub   = RST_SUB_START_CODE;
  bit         idle_on   = 1'b1;
  int         stall_left = 0;
  int         sent_bytes = 0;

  rdm_frame_parser dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_rdm_frame_parser: done, errors");
    $finish;
  end

  // output side: check each transfer, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_item(out_data_o);
    if (!idle_on) stall_left = 0;
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [7:0] fill_byte(int unsigned fill);
    if (fill == 1) return 8'h00;
    if (fill == 2) return 8'hFF;
    return 8'($urandom);
  endfunction

  // well-formed frame for the current codes, checksum appended
  function automatic void build_frame(int unsigned plen, int unsigned fill);
    logic [15:0] total;
    octets.delete();
    octets.push_back(cur_start);
    octets.push_back(cur_sub);
    octets.push_back(8'(MIN_MSG_LEN + plen));
    repeat (20) octets.push_back(fill_byte(fill));
    octets.push_back(8'(plen));
    repeat (plen) octets.push_back(fill_byte(fill));
    total = '0;
    foreach (octets[i]) total += octets[i];
    octets.push_back(total[15:8]);
    octets.push_back(total[7:0]);
  endfunction

  task automatic send_octets();
    rdm_in_t beat;
    for (int i = 0; i < octets.size(); i++) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      beat.rx_byte       = octets[i];
      beat.end_of_buffer = (i == octets.size() - 1);
      in_valid_i <= 1'b1;
      in_data_i  <= beat;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_byte(beat);
      sent_bytes++;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [7:0] sc, logic [7:0] sub);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_START_CODE;
    cfg_wdata_i <= sc;
    @(posedge clk_i);
    cfg_index_i <= CFG_SUB_START_CODE;
    cfg_wdata_i <= sub;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.start_byte = sc;
    sb.sub_code   = sub;
    cur_start     = sc;
    cur_sub       = sub;
  endtask

  initial begin
    int p;
    int mark;
    int bufs;
    int kind;
    int plen;
    int r;
    logic [7:0] sc;
    logic [7:0] sub;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed buffers at reset codes
    build_frame(0, 1);
    send_octets();
    build_frame(3, 2);
    octets.push_back(8'hA5);
    octets.push_back(8'h5A);
    send_octets();
    build_frame(2, 0);
    octets[octets.size() - 1] ^= 8'h01;
    send_octets();
    build_frame(0, 0);
    octets[0] ^= 8'h80;
    octets[1] ^= 8'h01;
    send_octets();
    build_frame(0, 0);
    octets[1] ^= 8'hFF;
    send_octets();
    build_frame(1, 0);
    octets[2] = 8'd0;
    send_octets();
    build_frame(1, 0);
    octets[2] = 8'd23;
    send_octets();
    build_frame(4, 0);
    octets[23] = 8'd5;
    send_octets();
    // bad header but too short: short wins
    build_frame(0, 0);
    octets[0] ^= 8'h01;
    octets = octets[0:19];
    send_octets();
    // ends on a data byte
    build_frame(6, 0);
    octets = octets[0:25];
    send_octets();
    // ends on the checksum high byte
    build_frame(2, 0);
    void'(octets.pop_back());
    send_octets();
    octets = {8'hCC};
    send_octets();
    // header error reported on the buffer's last byte
    build_frame(0, 0);
    octets[2] = 8'd30;
    octets = octets[0:25];
    send_octets();

    for (p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin sc = 8'h00; sub = 8'hFF; end
        1: begin sc = 8'hFF; sub = 8'h00; end
        4: begin sc = RST_START_CODE; sub = RST_SUB_START_CODE; end
        default: begin sc = 8'($urandom); sub = 8'($urandom); end
      endcase
      write_regs(sc, sub);
      mark = sent_bytes;
      bufs = 0;
      while (sent_bytes - mark < 40 || bufs < 1) begin
        idle_on = (p != 4) && ($urandom_range(0, 3) != 0);
        kind = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        if (r < 85) plen = $urandom_range(0, 12);
        else if (r < 96) plen = $urandom_range(13, 64);
        else plen = $urandom_range(200, 231);
        build_frame(plen, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
        if (kind < 50) begin
        end else if (kind < 58) begin
          octets[octets.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end else if (kind < 64) begin
          octets[0] ^= 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1) == 0) octets[1] ^= 8'($urandom_range(1, 255));
        end else if (kind < 70) begin
          octets[1] ^= 8'($urandom_range(1, 255));
        end else if (kind < 76) begin
          octets[2] = 8'($urandom_range(0, 23));
        end else if (kind < 82) begin
          octets[23] ^= 8'($urandom_range(1, 255));
        end else if (kind < 92) begin
          r = $urandom_range(1, octets.size() - 1);
          while (octets.size() > r) void'(octets.pop_back());
        end else begin
          octets.delete();
          repeat ($urandom_range(1, 40)) octets.push_back(8'($urandom));
          if ($urandom_range(0, 1) == 0) octets[0] = cur_start;
          if (octets.size() > 1 && $urandom_range(0, 3) == 0) octets[1] = cur_sub;
        end
        if (kind < 82 && $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) octets.push_back(8'($urandom));
        send_octets();
        bufs++;
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("tb_rdm_frame_parser: done, clean");
    end else begin
      $display("tb_rdm_frame_parser: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rdm_fp_pkg.sv
rtl/rdm_fp_parser.sv
rtl/rdm_fp_out_reg.sv
rtl/rdm_frame_parser.sv
test/tb_rdm_frame_parser.sv
